>>> src/vml_pkg.sv
`default_nettype none
package vml_pkg;

   localparam int FRAC_BITS = 16;

   localparam int IW = 32;
   localparam int PW = 2 * IW;
   localparam int CW = PW + 1;
   localparam int LOW_W = CW - IW;
   localparam int DLW = IW + LOW_W + 1;
   localparam int NW = 98;
   localparam int UPW = 18;
   localparam int STW = 2;

   localparam int MW = 31;
   localparam int POSW = $clog2(CW);
   localparam int SQW = 64;
   localparam int LENW = 32;
   localparam int ISQ_STEPS = SQW / 2;
   localparam int UQW = FRAC_BITS + 1;
   localparam int UW = UQW + 1;
   localparam int UR_W = FRAC_BITS + 34;

   localparam int EQW = 32;
   localparam int EYE_RW = NW + FRAC_BITS + 34;
   localparam int EYE_LAT = EQW + 3;

   localparam int FRONT_STAGES = 5;
   localparam int QDEPTH = 4;
   localparam int QAW = 2;
   localparam int NORM_LAT = 7 + ISQ_STEPS + FRAC_BITS;
   localparam int EYE_DLY = NORM_LAT - EYE_LAT;
   localparam int BACK_STAGES = NORM_LAT + 2;

   localparam logic [STW-1:0] ST_OK = 2'd0;
   localparam logic [STW-1:0] ST_SINGULAR = 2'd1;
   localparam logic [STW-1:0] ST_ZERO_VEC = 2'd2;

   localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
   localparam logic signed [33:0] S32_MIN = -34'sd2147483648;
   localparam logic signed [33:0] UP_MAX = 34'sd131071;
   localparam logic signed [33:0] UP_MIN = -34'sd131072;

   typedef struct packed {
      logic [2:0][CW-1:0] upc;
      logic [2:0][CW-1:0] fwc;
      logic [NW-1:0]      det;
      logic [2:0][NW-1:0] num;
   } vml_work_type;

endpackage
`default_nettype wire

>>> src/vml_if.sv
`default_nettype none
interface vml_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] rot_00;
   logic signed [31:0] rot_01;
   logic signed [31:0] rot_02;
   logic signed [31:0] rot_10;
   logic signed [31:0] rot_11;
   logic signed [31:0] rot_12;
   logic signed [31:0] rot_20;
   logic signed [31:0] rot_21;
   logic signed [31:0] rot_22;
   logic signed [31:0] trans_x;
   logic signed [31:0] trans_y;
   logic signed [31:0] trans_z;

   modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, input ready);
   modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                 rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, output ready);
endinterface

interface vml_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] eye_x;
   logic signed [31:0] eye_y;
   logic signed [31:0] eye_z;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic signed [31:0] center_z;
   logic signed [17:0] up_x;
   logic signed [17:0] up_y;
   logic signed [17:0] up_z;
   logic [1:0] status;

   modport source (output valid, eye_x, eye_y, eye_z, center_x, center_y, center_z,
                   up_x, up_y, up_z, status, input ready);
   modport sink (input valid, eye_x, eye_y, eye_z, center_x, center_y, center_z,
                 up_x, up_y, up_z, status, output ready);
endinterface
`default_nettype wire

>>> src/vml_front.sv
`default_nettype none
module vml_front
   import vml_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   vml_req_if.sink      req,
   input  logic         q_full,
   output logic         push,
   output vml_work_type push_data
);

   logic adv;
   logic [FRONT_STAGES-1:0] fv_ff, fv_in;

   logic signed [IW-1:0] a_ff [3][3];
   logic signed [IW-1:0] t_ff [3];
   logic signed [PW-1:0] pa_ff [3][3];
   logic signed [PW-1:0] pb_ff [3][3];
   logic signed [IW-1:0] a1_ff [3];
   logic signed [IW-1:0] t1_ff [3];
   logic signed [CW-1:0] c_ff [3][3];
   logic signed [IW-1:0] a2_ff [3];
   logic signed [IW-1:0] t2_ff [3];
   logic signed [PW-1:0] dh_ff [3];
   logic signed [DLW-1:0] dl_ff [3];
   logic signed [PW-1:0] nh_ff [3][3];
   logic signed [DLW-1:0] nl_ff [3][3];
   logic [CW-1:0] upc3_ff [3];
   logic [CW-1:0] fwc3_ff [3];
   logic signed [NW-1:0] det_ff, det_in;
   logic signed [NW-1:0] n_ff [3];
   logic signed [NW-1:0] n_in [3];
   logic [CW-1:0] upc4_ff [3];
   logic [CW-1:0] fwc4_ff [3];

   function automatic logic signed [NW-1:0] join_pp(input logic signed [PW-1:0] h,
                                                    input logic signed [DLW-1:0] l);
      join_pp = (NW'(h) <<< LOW_W) + NW'(l);
   endfunction

   assign adv = !(fv_ff[FRONT_STAGES-1] && q_full);
   assign req.ready = adv;
   assign push = fv_ff[FRONT_STAGES-1] && adv;
   assign fv_in = {fv_ff[FRONT_STAGES-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (adv) begin
         fv_ff <= fv_in;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0][0] <= req.rot_00;
         a_ff[0][1] <= req.rot_01;
         a_ff[0][2] <= req.rot_02;
         a_ff[1][0] <= req.rot_10;
         a_ff[1][1] <= req.rot_11;
         a_ff[1][2] <= req.rot_12;
         a_ff[2][0] <= req.rot_20;
         a_ff[2][1] <= req.rot_21;
         a_ff[2][2] <= req.rot_22;
         t_ff[0] <= req.trans_x;
         t_ff[1] <= req.trans_y;
         t_ff[2] <= req.trans_z;
      end
   end

   // cofactor products
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int I1 = (i + 1) % 3;
         localparam int I2 = (i + 2) % 3;
         localparam int J1 = (j + 1) % 3;
         localparam int J2 = (j + 2) % 3;
         always_ff @(posedge clock) begin
            if (adv) begin
               pa_ff[i][j] <= a_ff[I1][J1] * a_ff[I2][J2];
               pb_ff[i][j] <= a_ff[I1][J2] * a_ff[I2][J1];
            end
         end
      end
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + join_pp(dh_ff[j], dl_ff[j]);
      end
      for (int i = 0; i < 3; i++) begin
         n_in[i] = '0;
         for (int j = 0; j < 3; j++) begin
            n_in[i] = n_in[i] + join_pp(nh_ff[i][j], nl_ff[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= a_ff[0][i];
            t1_ff[i] <= t_ff[i];
            a2_ff[i] <= a1_ff[i];
            t2_ff[i] <= t1_ff[i];
            for (int j = 0; j < 3; j++) begin
               c_ff[i][j] <= CW'(pa_ff[i][j]) - CW'(pb_ff[i][j]);
            end
            // split products: high word times 2^LOW_W plus unsigned low part
            dh_ff[i] <= a2_ff[i] * $signed(c_ff[0][i][CW-1:LOW_W]);
            dl_ff[i] <= a2_ff[i] * $signed({1'b0, c_ff[0][i][LOW_W-1:0]});
            for (int j = 0; j < 3; j++) begin
               nh_ff[i][j] <= t2_ff[j] * $signed(c_ff[j][i][CW-1:LOW_W]);
               nl_ff[i][j] <= t2_ff[j] * $signed({1'b0, c_ff[j][i][LOW_W-1:0]});
            end
            upc3_ff[i] <= c_ff[1][i];
            fwc3_ff[i] <= c_ff[2][i];
            n_ff[i] <= n_in[i];
            upc4_ff[i] <= upc3_ff[i];
            fwc4_ff[i] <= fwc3_ff[i];
         end
         det_ff <= det_in;
      end
   end

   always_comb begin
      push_data.det = det_ff;
      for (int i = 0; i < 3; i++) begin
         push_data.upc[i] = upc4_ff[i];
         push_data.fwc[i] = fwc4_ff[i];
         push_data.num[i] = n_ff[i];
      end
   end

endmodule
`default_nettype wire

>>> src/vml_queue.sv
`default_nettype none
module vml_queue
   import vml_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  vml_work_type push_data,
   input  logic         pop,
   output logic         full,
   output logic         empty,
   output vml_work_type head
);

   vml_work_type mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QAW:0] cnt_ff, cnt_in;

   assign full = cnt_ff == (QAW + 1)'(QDEPTH);
   assign empty = cnt_ff == '0;
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> src/vml_norm.sv
`default_nettype none
module vml_norm
   import vml_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [2:0][CW-1:0]  vec,
   input  logic                flip,
   output logic [2:0][UW-1:0]  unit,
   output logic                zero
);

   logic [3:0] tag_ff [NORM_LAT];
   logic [3:0] tag_in;
   logic [CW-1:0] mag_ff [3];
   logic [CW-1:0] m2_ff [3];
   logic [CW-1:0] orv;
   logic [POSW-1:0] pos_in, pos_ff;
   logic [CW-1:0] sh_val [3];
   logic [MW-1:0] m3_ff [3];
   logic [MW-1:0] m4_ff [3];
   logic [2*MW-1:0] sq_ff [3];
   logic [SQW-1:0] x_ff [ISQ_STEPS+1];
   logic [SQW-1:0] r_ff [ISQ_STEPS+1];
   logic [MW-1:0] mq_ff [ISQ_STEPS+1][3];
   logic [LENW-1:0] len;
   logic [UR_W-1:0] rem_ff [UQW+1][3];
   logic [LENW:0] den_ff [UQW+1];
   logic [UQW-1:0] q_ff [UQW+1][3];

   assign tag_in[3] = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
   for (genvar i = 0; i < 3; i++) begin : g_tag
      assign tag_in[i] = vec[i][CW-1] ^ flip;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= tag_in;
         for (int k = 1; k < NORM_LAT; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // leading one of the largest magnitude
   always_comb begin
      orv = m2_ff[0] | m2_ff[1] | m2_ff[2];
      pos_in = '0;
      for (int b = 0; b < CW; b++) begin
         if (mag_ff[0][b] | mag_ff[1][b] | mag_ff[2][b]) begin
            pos_in = POSW'(b);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (pos_ff > POSW'(MW - 1)) begin
            sh_val[i] = m2_ff[i] >> (pos_ff - POSW'(MW - 1));
         end else begin
            sh_val[i] = m2_ff[i] << (POSW'(MW - 1) - pos_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= pos_in;
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= vec[i][CW-1] ? CW'(-vec[i]) : vec[i];
            m2_ff[i] <= mag_ff[i] & ~{CW{orv == '0 && 1'b0}};
            m3_ff[i] <= sh_val[i][MW-1:0];
            sq_ff[i] <= m3_ff[i] * m3_ff[i];
            m4_ff[i] <= m3_ff[i];
         end
         x_ff[0] <= SQW'(sq_ff[0]) + SQW'(sq_ff[1]) + SQW'(sq_ff[2]);
         r_ff[0] <= '0;
         mq_ff[0] <= m4_ff;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
      localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
      logic [SQW-1:0] trial;
      assign trial = r_ff[k] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (x_ff[k] >= trial) begin
               x_ff[k+1] <= x_ff[k] - trial;
               r_ff[k+1] <= (r_ff[k] >> 1) + BIT;
            end else begin
               x_ff[k+1] <= x_ff[k];
               r_ff[k+1] <= r_ff[k] >> 1;
            end
            mq_ff[k+1] <= mq_ff[k];
         end
      end
   end

   assign len = r_ff[ISQ_STEPS][LENW-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= {len, 1'b0};
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (UR_W'(mq_ff[ISQ_STEPS][i]) << (FRAC_BITS + 1)) + UR_W'(len);
            q_ff[0][i] <= '0;
         end
      end
   end

   // rounded quotient, one bit per stage
   for (genvar s = 0; s < UQW; s++) begin : g_div
      localparam int SH = UQW - 1 - s;
      logic [UR_W-1:0] dsh;
      assign dsh = UR_W'(den_ff[s]) << SH;
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s+1] <= den_ff[s];
            for (int i = 0; i < 3; i++) begin
               if (rem_ff[s][i] >= dsh) begin
                  rem_ff[s+1][i] <= rem_ff[s][i] - dsh;
                  q_ff[s+1][i] <= q_ff[s][i] | (UQW'(1) << SH);
               end else begin
                  rem_ff[s+1][i] <= rem_ff[s][i];
                  q_ff[s+1][i] <= q_ff[s][i];
               end
            end
         end
      end
   end

   assign zero = tag_ff[NORM_LAT-1][3];
   for (genvar i = 0; i < 3; i++) begin : g_out
      assign unit[i] = tag_ff[NORM_LAT-1][i] ? -UW'(q_ff[UQW][i]) : UW'(q_ff[UQW][i]);
   end

endmodule
`default_nettype wire

>>> src/vml_back.sv
`default_nettype none
module vml_back
   import vml_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  vml_work_type q_head,
   output logic         pop,
   vml_rsp_if.source    rsp
);

   logic adv;
   logic [BACK_STAGES-1:0] bv_ff, bv_in;
   vml_work_type w_ff;

   logic dz_ff [NORM_LAT+1];
   logic det_neg;
   logic [NW-1:0] absdet;
   logic [NW-1:0] absn [3];

   logic [EYE_RW-1:0] erem_ff [EQW+2][3];
   logic [NW:0] eden_ff [EQW+2];
   logic [EQW-1:0] eq_ff [EQW+2][3];
   logic [2:0] eneg_ff [EQW+2];
   logic [2:0] eovf_ff [EQW+2];
   logic [EQW-1:0] eye_ff [3];
   logic [EQW-1:0] ed_ff [EYE_DLY][3];

   logic [2:0][UW-1:0] upu, fwu;
   logic up_zero, fw_zero;

   logic signed [33:0] csum [3];
   logic signed [33:0] uext [3];
   logic [31:0] eye_o_in [3];
   logic [31:0] ctr_o_in [3];
   logic [UPW-1:0] up_o_in [3];
   logic [STW-1:0] st_in;
   logic [31:0] eye_o_ff [3];
   logic [31:0] ctr_o_ff [3];
   logic [UPW-1:0] up_o_ff [3];
   logic [STW-1:0] st_ff;

   assign adv = !bv_ff[BACK_STAGES-1] || rsp.ready;
   assign pop = adv && !q_empty;
   assign bv_in = {bv_ff[BACK_STAGES-2:0], !q_empty};
   assign det_neg = w_ff.det[NW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else if (adv) begin
         bv_ff <= bv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff <= q_head;
         dz_ff[0] <= q_head.det == '0;
         for (int k = 1; k < NORM_LAT + 1; k++) begin
            dz_ff[k] <= dz_ff[k-1];
         end
      end
   end

   vml_norm u_up (
      .clock (clock),
      .en    (adv),
      .vec   (w_ff.upc),
      .flip  (det_neg),
      .unit  (upu),
      .zero  (up_zero)
   );

   vml_norm u_fwd (
      .clock (clock),
      .en    (adv),
      .vec   (w_ff.fwc),
      .flip  (!det_neg),
      .unit  (fwu),
      .zero  (fw_zero)
   );

   // eye: rounded quotient of numerator over determinant
   always_comb begin
      absdet = det_neg ? -w_ff.det : w_ff.det;
      for (int i = 0; i < 3; i++) begin
         absn[i] = w_ff.num[i][NW-1] ? -w_ff.num[i] : w_ff.num[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         eden_ff[0] <= {absdet, 1'b0};
         for (int i = 0; i < 3; i++) begin
            erem_ff[0][i] <= (EYE_RW'(absn[i]) << (FRAC_BITS + 1)) + EYE_RW'(absdet);
            eq_ff[0][i] <= '0;
            eneg_ff[0][i] <= ~(w_ff.num[i][NW-1] ^ det_neg);
            eovf_ff[0][i] <= 1'b0;
            eovf_ff[1][i] <= erem_ff[0][i] >= (EYE_RW'(eden_ff[0]) << EQW);
         end
         eden_ff[1] <= eden_ff[0];
         erem_ff[1] <= erem_ff[0];
         eq_ff[1] <= eq_ff[0];
         eneg_ff[1] <= eneg_ff[0];
      end
   end

   for (genvar s = 0; s < EQW; s++) begin : g_ediv
      localparam int SH = EQW - 1 - s;
      logic [EYE_RW-1:0] dsh;
      assign dsh = EYE_RW'(eden_ff[s+1]) << SH;
      always_ff @(posedge clock) begin
         if (adv) begin
            eden_ff[s+2] <= eden_ff[s+1];
            eneg_ff[s+2] <= eneg_ff[s+1];
            eovf_ff[s+2] <= eovf_ff[s+1];
            for (int i = 0; i < 3; i++) begin
               if (erem_ff[s+1][i] >= dsh) begin
                  erem_ff[s+2][i] <= erem_ff[s+1][i] - dsh;
                  eq_ff[s+2][i] <= eq_ff[s+1][i] | (EQW'(1) << SH);
               end else begin
                  erem_ff[s+2][i] <= erem_ff[s+1][i];
                  eq_ff[s+2][i] <= eq_ff[s+1][i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (eovf_ff[EQW+1][i] || eq_ff[EQW+1][i][EQW-1]) begin
               eye_ff[i] <= eneg_ff[EQW+1][i] ? S32_MIN[31:0] : S32_MAX[31:0];
            end else begin
               eye_ff[i] <= eneg_ff[EQW+1][i] ? -eq_ff[EQW+1][i] : eq_ff[EQW+1][i];
            end
            ed_ff[0][i] <= eye_ff[i];
            for (int k = 1; k < EYE_DLY; k++) begin
               ed_ff[k][i] <= ed_ff[k-1][i];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         csum[i] = 34'($signed(ed_ff[EYE_DLY-1][i])) + 34'($signed(fwu[i]));
         uext[i] = 34'($signed(upu[i]));
         eye_o_in[i] = '0;
         ctr_o_in[i] = '0;
         up_o_in[i] = '0;
      end
      if (dz_ff[NORM_LAT]) begin
         st_in = ST_SINGULAR;
      end else if (up_zero || fw_zero) begin
         st_in = ST_ZERO_VEC;
      end else begin
         st_in = ST_OK;
         for (int i = 0; i < 3; i++) begin
            eye_o_in[i] = ed_ff[EYE_DLY-1][i];
            if (csum[i] > S32_MAX) begin
               ctr_o_in[i] = S32_MAX[31:0];
            end else if (csum[i] < S32_MIN) begin
               ctr_o_in[i] = S32_MIN[31:0];
            end else begin
               ctr_o_in[i] = csum[i][31:0];
            end
            if (uext[i] > UP_MAX) begin
               up_o_in[i] = UP_MAX[UPW-1:0];
            end else if (uext[i] < UP_MIN) begin
               up_o_in[i] = UP_MIN[UPW-1:0];
            end else begin
               up_o_in[i] = uext[i][UPW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         eye_o_ff <= eye_o_in;
         ctr_o_ff <= ctr_o_in;
         up_o_ff <= up_o_in;
         st_ff <= st_in;
      end
   end

   assign rsp.valid = bv_ff[BACK_STAGES-1];
   assign rsp.eye_x = eye_o_ff[0];
   assign rsp.eye_y = eye_o_ff[1];
   assign rsp.eye_z = eye_o_ff[2];
   assign rsp.center_x = ctr_o_ff[0];
   assign rsp.center_y = ctr_o_ff[1];
   assign rsp.center_z = ctr_o_ff[2];
   assign rsp.up_x = up_o_ff[0];
   assign rsp.up_y = up_o_ff[1];
   assign rsp.up_z = up_o_ff[2];
   assign rsp.status = st_ff;

endmodule
`default_nettype wire

>>> src/view_matrix_to_look_at_top.sv
`default_nettype none
// Recovers eye, center and up of a look-at camera from a Q16.16 view matrix (rotation part
// and translation). One request is taken per cycle unless back-pressure has filled the queue,
// and one response leaves per request, in order; the delay from acceptance to response is set
// mainly by the 32-step square root and the per-bit quotient stages of the normalization pipeline (5 front
// stages, the queue, and FRAC_BITS + 41 back stages). A singular rotation returns status 1
// with zeroed fields; eye and center saturate to 32 bits and up to 18 bits.
module view_matrix_to_look_at_top
   import vml_pkg::*;
(
   input logic       clock,
   input logic       reset,
   vml_req_if.sink   req,
   vml_rsp_if.source rsp
);

   logic         q_full;
   logic         q_empty;
   logic         push;
   logic         pop;
   vml_work_type push_data;
   vml_work_type q_head;

   vml_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   vml_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   vml_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule
`default_nettype wire
